@@ design/u8qsb_pkg.sv @@
// Package for the uint8 requantizer: payload structs, configuration register
// indexes and the fixed widths of the datapath. No dependencies.
package u8qsb_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int PIX_W  = 8;
    localparam int COEF_W = 32;
    localparam int CFG_W  = 32;

    // Datapath widths (fraction bits do not change them)
    localparam int TW = PIX_W + COEF_W;  // |pixel - zero| * src_scale
    localparam int UW = 72;              // t * |chan_scale|
    localparam int WW = UW + 2;          // signed t*c + bias
    localparam int WM = WW - 1;          // |w|
    localparam int XW = WM + COEF_W;     // |w| * dst_inv_scale

    localparam int VAL_W = 10;
    localparam logic [VAL_W-1:0] SAT_MAG = VAL_W'(1000);
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [1:0] {
        CFG_SRC_ZERO  = 2'd0,
        CFG_SRC_SCALE = 2'd1,
        CFG_DST_INV   = 2'd2,
        CFG_DST_ZERO  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]         pixel_in;
        logic signed [COEF_W-1:0] chan_scale;
        logic signed [COEF_W-1:0] chan_bias;
        logic                     last_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_out;
    } t_out_item;

endpackage

@@ design/uint8_quantized_scale_bias.sv @@
// uint8 requantizer with per-channel scale and bias, ten-stage pipeline.
// Depends on u8qsb_pkg (payload structs, register indexes, widths).
//
// Usage:
//   Input channel: a transaction is accepted at a rising edge where start is
//   high and busy is low. busy is always low: one transaction per cycle.
//   Result channel: o_valid marks o_out for exactly one cycle; the receiver
//   takes it at the edge that ends that cycle and cannot hold it off.
//   Configuration: i_cfg_we writes i_cfg_data into the register selected by
//   i_cfg_idx at the same edge (0 src_zero, 1 src_scale, 2 dst_inv_scale,
//   3 dst_zero). Write only while no transaction is in flight.
// Timing: an accepted transaction passes through the stage registers listed
//   below before its result shows on o_out. Throughput: one per cycle.
// Stages: |d| and |c|; d*src_scale; partial products of t*c; sum;
//   sign and bias; |w|; partial products of |w|*dst_inv_scale; sum;
//   round half to even and clip magnitude; add dst_zero and saturate.
//   The 32-bit multipliers set the stage depth.
// Reset: clears all valid bits and loads the register reset values.
//   Results in flight are dropped; otherwise none is lost, as the receiver never stalls.
module uint8_quantized_scale_bias
    import u8qsb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_in,
    output logic               o_valid,
    output t_out_item          o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int SH3 = 3 * FRAC_BITS;
    localparam int QW  = XW - SH3;
    localparam int HW  = WM - 64;       // top chunk of |w|

    // Configuration registers
    logic [PIX_W-1:0]  r_src_zero;
    logic [COEF_W-1:0] r_src_scale;
    logic [COEF_W-1:0] r_dst_inv;
    logic [PIX_W-1:0]  r_dst_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_zero  <= '0;
            r_src_scale <= COEF_W'(65536);
            r_dst_inv   <= COEF_W'(65536);
            r_dst_zero  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_ZERO:  r_src_zero  <= i_cfg_data[PIX_W-1:0];
                CFG_SRC_SCALE: r_src_scale <= i_cfg_data;
                CFG_DST_INV:   r_dst_inv   <= i_cfg_data;
                CFG_DST_ZERO:  r_dst_zero  <= i_cfg_data[PIX_W-1:0];
                default:       r_src_zero  <= r_src_zero;
            endcase
        end
    end

    // Never stall the input: every stage advances each cycle
    assign busy = 1'b0;

    logic in_acc;
    assign in_acc = start && !busy;

    // Valid bits travel alongside the payload
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0; r8_v <= 1'b0;
            r9_v <= 1'b0; r_out_v <= 1'b0;
        end else begin
            r1_v <= in_acc; r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v;   r6_v <= r5_v; r7_v <= r6_v; r8_v <= r7_v;
            r9_v <= r8_v;   r_out_v <= r9_v;
        end
    end

    // Stage 1: magnitudes and signs of the activation offset and the scale
    logic               r1_dneg, r1_cneg, r1_last;
    logic [PIX_W-1:0]   r1_dmag;
    logic [COEF_W-1:0]  r1_cmag;
    logic signed [COEF_W-1:0] r1_cb;

    always_ff @(posedge i_clk) begin
        r1_dneg <= i_in.pixel_in < r_src_zero;
        r1_dmag <= (i_in.pixel_in < r_src_zero) ? (r_src_zero - i_in.pixel_in)
                                                : (i_in.pixel_in - r_src_zero);
        r1_cneg <= i_in.chan_scale[COEF_W-1];
        r1_cmag <= i_in.chan_scale[COEF_W-1] ? (~i_in.chan_scale + COEF_W'(1))
                                             : i_in.chan_scale;
        r1_cb   <= i_in.chan_bias;
        r1_last <= i_in.last_in;
    end

    // Stage 2: t = |d| * src_scale
    logic               r2_s, r2_last;
    logic [TW-1:0]      r2_tmag;
    logic [COEF_W-1:0]  r2_cmag;
    logic signed [COEF_W-1:0] r2_cb;

    always_ff @(posedge i_clk) begin
        r2_tmag <= TW'(r1_dmag) * TW'(r_src_scale);
        r2_s    <= r1_dneg ^ r1_cneg;
        r2_cmag <= r1_cmag;
        r2_cb   <= r1_cb;
        r2_last <= r1_last;
    end

    // Stage 3: partial products of t * |c|
    logic               r3_s, r3_last;
    logic [63:0]        r3_pl;
    logic [TW-1:0]      r3_ph;
    logic signed [COEF_W-1:0] r3_cb;

    always_ff @(posedge i_clk) begin
        r3_pl   <= 64'(r2_tmag[31:0]) * 64'(r2_cmag);
        r3_ph   <= TW'(r2_tmag[TW-1:32]) * TW'(r2_cmag);
        r3_s    <= r2_s;
        r3_cb   <= r2_cb;
        r3_last <= r2_last;
    end

    // Stage 4: sum the partial products
    logic               r4_s, r4_last;
    logic [UW-1:0]      r4_u;
    logic signed [COEF_W-1:0] r4_cb;

    always_ff @(posedge i_clk) begin
        r4_u    <= UW'(r3_pl) + (UW'(r3_ph) << 32);
        r4_s    <= r3_s;
        r4_cb   <= r3_cb;
        r4_last <= r3_last;
    end

    // Stage 5: apply the sign and add the bias aligned to 2F fraction bits
    logic signed [WW-1:0] bias_ext, u_ext;
    logic signed [WW-1:0] r5_w;
    logic                 r5_last;

    assign bias_ext = WW'(r4_cb) <<< FRAC_BITS;
    assign u_ext    = $signed(WW'(r4_u));

    always_ff @(posedge i_clk) begin
        r5_w    <= (r4_s ? -u_ext : u_ext) + bias_ext;
        r5_last <= r4_last;
    end

    // Stage 6: magnitude of w
    logic               r6_neg, r6_last;
    logic [WM-1:0]      r6_wmag;

    always_ff @(posedge i_clk) begin
        r6_neg  <= r5_w[WW-1];
        r6_wmag <= r5_w[WW-1] ? WM'(-r5_w) : WM'(r5_w);
        r6_last <= r5_last;
    end

    // Stage 7: partial products of |w| * dst_inv_scale
    logic               r7_neg, r7_last;
    logic [63:0]        r7_p0, r7_p1;
    logic [HW+31:0]     r7_p2;

    always_ff @(posedge i_clk) begin
        r7_p0   <= 64'(r6_wmag[31:0]) * 64'(r_dst_inv);
        r7_p1   <= 64'(r6_wmag[63:32]) * 64'(r_dst_inv);
        r7_p2   <= (HW+32)'(r6_wmag[WM-1:64]) * (HW+32)'(r_dst_inv);
        r7_neg  <= r6_neg;
        r7_last <= r6_last;
    end

    // Stage 8: x = |w| * dst_inv_scale with 3F fraction bits
    logic               r8_neg, r8_last;
    logic [XW-1:0]      r8_x;

    always_ff @(posedge i_clk) begin
        r8_x    <= XW'(r7_p0) + (XW'(r7_p1) << 32) + (XW'(r7_p2) << 64);
        r8_neg  <= r7_neg;
        r8_last <= r7_last;
    end

    // Stage 9: round half to even, clip the magnitude
    logic [QW-1:0]    q_trunc;
    logic             q_inc, q_big;
    logic             r9_neg, r9_last;
    logic [VAL_W-1:0] r9_val;

    assign q_trunc = r8_x[XW-1:SH3];
    assign q_inc   = r8_x[SH3-1] && ((r8_x[SH3-2:0] != '0) || q_trunc[0]);
    // A truncated value at or above the clip level stays clipped after rounding
    assign q_big   = q_trunc >= QW'(SAT_MAG);

    always_ff @(posedge i_clk) begin
        r9_val  <= q_big ? SAT_MAG : (q_trunc[VAL_W-1:0] + VAL_W'(q_inc));
        r9_neg  <= r8_neg;
        r9_last <= r8_last;
    end

    // Stage 10: add the output zero point and saturate to 0..255
    logic signed [VAL_W+1:0] zsum;
    t_out_item               r_out;

    assign zsum = r9_neg ? ($signed((VAL_W+2)'(r_dst_zero)) - $signed((VAL_W+2)'(r9_val)))
                         : ($signed((VAL_W+2)'(r_dst_zero)) + $signed((VAL_W+2)'(r9_val)));

    always_ff @(posedge i_clk) begin
        if (zsum[VAL_W+1]) begin
            r_out.pixel_out <= '0;
        end else if (zsum > $signed((VAL_W+2)'(PIX_MAX))) begin
            r_out.pixel_out <= PIX_MAX;
        end else begin
            r_out.pixel_out <= zsum[PIX_W-1:0];
        end
        r_out.last_out <= r9_last;
    end

    assign o_valid = r_out_v;
    assign o_out   = r_out;

`ifndef ASSERT_OFF
    // A result appears only for an accepted transaction, delayed by the pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(in_acc, 10))
        else $error("result without an accepted transaction");

    // The rounded magnitude never exceeds the clip level
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r9_v |-> (r9_val <= SAT_MAG))
        else $error("rounded magnitude above clip level");
`endif

endmodule
